### rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; every other file imports this package.
package mlr_pkg;

   localparam int COORD_W  = 17;  // endpoint and walk coordinates, signed
   localparam int DELTA_W  = 18;  // dx, dy, |dy| and screen row, signed
   localparam int STEP_W   = 19;  // doubled deltas, signed
   localparam int DEC_W    = 21;  // decision term, signed
   localparam int IN_W     = 16;
   localparam int COLOUR_W = 24;
   localparam int PIX_W    = 9;

   localparam int DEF_SCREEN_WIDTH  = 512;
   localparam int DEF_SCREEN_HEIGHT = 512;

   // power of two, so the queue pointers wrap by themselves
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_SHALLOW    = 2'd0,
      MODE_STEEP_UP   = 2'd1,
      MODE_STEEP_DOWN = 2'd2
   } mode_type;

   // classified command handed from front to back
   typedef struct packed {
      opcode_type                  op;
      mode_type                    mode;
      logic signed [COORD_W-1:0]   x0;
      logic signed [COORD_W-1:0]   y0;
      logic signed [COORD_W-1:0]   stop;
      logic signed [DEC_W-1:0]     decision;
      logic signed [STEP_W-1:0]    step_a;
      logic signed [STEP_W-1:0]    step_b;
      logic                        y_down;
      logic [COLOUR_W-1:0]         colour;
   } cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0]    col;
      logic [PIX_W-1:0]    row;
      logic [COLOUR_W-1:0] colour;
      logic                write_enable;
      logic                last;
   } pixel_type;

endpackage

### rtl/mlr_queue.sv
// Small first-in first-out word queue used between the rasterizer stages.
// Depends on mlr_pkg for the depth.
module mlr_queue
   import mlr_pkg::*;
#(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/mlr_front.sv
// Front end: orders the endpoints, classifies the line and sets up the
// doubled decision term. Depends on mlr_pkg.
module mlr_front
   import mlr_pkg::*;
(
   input  logic                       opcode,
   input  logic signed [IN_W-1:0]     start_x,
   input  logic signed [IN_W-1:0]     start_y,
   input  logic signed [IN_W-1:0]     end_x,
   input  logic signed [IN_W-1:0]     end_y,
   input  logic [COLOUR_W-1:0]        line_colour,
   output cmd_type                    cmd
);

   logic                      swap;
   logic signed [DELTA_W-1:0] x0, y0, x1, y1;
   logic signed [DELTA_W-1:0] dx, dy, ady;
   logic signed [STEP_W-1:0]  two_ady, two_dx;

   always_comb begin
      swap = (end_x < start_x);
      x0   = DELTA_W'(swap ? end_x : start_x);
      y0   = DELTA_W'(swap ? end_y : start_y);
      x1   = DELTA_W'(swap ? start_x : end_x);
      y1   = DELTA_W'(swap ? start_y : end_y);
      dx   = x1 - x0;
      dy   = y1 - y0;
      ady  = dy[DELTA_W-1] ? -dy : dy;
      two_ady = {ady, 1'b0};
      two_dx  = {dx, 1'b0};

      cmd.op     = opcode_type'(opcode);
      cmd.x0     = COORD_W'(x0);
      cmd.y0     = COORD_W'(y0);
      cmd.step_a = two_ady;
      cmd.step_b = two_dx;
      cmd.y_down = dy[DELTA_W-1];
      cmd.colour = line_colour;

      if (dx >= ady) begin
         cmd.mode     = MODE_SHALLOW;
         cmd.stop     = COORD_W'(x1);
         cmd.decision = DEC_W'(two_ady) - DEC_W'(dx);
      end else if (!dy[DELTA_W-1]) begin
         cmd.mode     = MODE_STEEP_UP;
         cmd.stop     = COORD_W'(y1);
         cmd.decision = DEC_W'(dy) - DEC_W'(two_dx);
      end else begin
         cmd.mode     = MODE_STEEP_DOWN;
         cmd.stop     = COORD_W'(y1);
         cmd.decision = DEC_W'(two_dx) - DEC_W'(ady);
      end
   end

endmodule

### rtl/mlr_back.sv
// Back end: holds the line being walked and turns each step command of an active line
// into one pixel word. Depends on mlr_pkg.
module mlr_back
   import mlr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      cmd_empty,
   output logic      cmd_pop,
   output pixel_type pix,
   output logic      pix_push,
   input  logic      pix_full
);

   localparam logic signed [DELTA_W-1:0] W_LIM   = DELTA_W'(SCREEN_WIDTH);
   localparam logic signed [DELTA_W-1:0] H_LIM   = DELTA_W'(SCREEN_HEIGHT);
   localparam logic signed [DELTA_W-1:0] ROW_TOP = DELTA_W'(SCREEN_HEIGHT - 1);

   logic                      active_ff, active_in;
   mode_type                  mode_ff, mode_in;
   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;
   logic signed [COORD_W-1:0] stop_ff, stop_in;
   logic signed [DEC_W-1:0]   dec_ff, dec_in;
   logic signed [STEP_W-1:0]  step_a_ff, step_a_in;
   logic signed [STEP_W-1:0]  step_b_ff, step_b_in;
   logic                      y_down_ff, y_down_in;
   logic [COLOUR_W-1:0]       colour_ff, colour_in;

   logic                      is_start, emit, last, on_screen, dec_pos, dec_neg;
   logic signed [DELTA_W-1:0] x_ext, row;
   logic signed [DEC_W-1:0]   a_ext, b_ext;

   always_comb begin
      is_start = !cmd_empty && (cmd.op == OP_START);
      emit     = !cmd_empty && (cmd.op == OP_STEP) && active_ff;
      cmd_pop  = !cmd_empty && (!emit || !pix_full);
      pix_push = emit && !pix_full;

      x_ext     = DELTA_W'(x_ff);
      row       = ROW_TOP - DELTA_W'(y_ff);
      on_screen = !x_ext[DELTA_W-1] && (x_ext < W_LIM) &&
                  !row[DELTA_W-1] && (row < H_LIM);
      last      = (mode_ff == MODE_SHALLOW) ? (x_ff == stop_ff) : (y_ff == stop_ff);

      pix.col          = on_screen ? x_ff[PIX_W-1:0] : '0;
      pix.row          = on_screen ? row[PIX_W-1:0] : '0;
      pix.colour       = colour_ff;
      pix.write_enable = on_screen;
      pix.last         = last;

      dec_neg = dec_ff[DEC_W-1];
      dec_pos = !dec_neg && (dec_ff != '0);
      a_ext   = DEC_W'(step_a_ff);
      b_ext   = DEC_W'(step_b_ff);

      active_in = active_ff;
      mode_in   = mode_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      stop_in   = stop_ff;
      dec_in    = dec_ff;
      step_a_in = step_a_ff;
      step_b_in = step_b_ff;
      y_down_in = y_down_ff;
      colour_in = colour_ff;

      if (cmd_pop && is_start) begin
         // a start abandons whatever line was in progress
         active_in = 1'b1;
         mode_in   = cmd.mode;
         x_in      = cmd.x0;
         y_in      = cmd.y0;
         stop_in   = cmd.stop;
         dec_in    = cmd.decision;
         step_a_in = cmd.step_a;
         step_b_in = cmd.step_b;
         y_down_in = cmd.y_down;
         colour_in = cmd.colour;
      end else if (pix_push) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            case (mode_ff)
               MODE_SHALLOW: begin
                  x_in = x_ff + COORD_W'(1);
                  if (dec_pos) begin
                     y_in   = y_down_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
                     dec_in = dec_ff - b_ext + a_ext;
                  end else begin
                     dec_in = dec_ff + a_ext;
                  end
               end
               MODE_STEEP_UP: begin
                  y_in = y_ff + COORD_W'(1);
                  if (dec_neg) begin
                     x_in   = x_ff + COORD_W'(1);
                     dec_in = dec_ff + a_ext - b_ext;
                  end else begin
                     dec_in = dec_ff - b_ext;
                  end
               end
               default: begin
                  y_in = y_ff - COORD_W'(1);
                  if (dec_pos) begin
                     x_in   = x_ff + COORD_W'(1);
                     dec_in = dec_ff - a_ext + b_ext;
                  end else begin
                     dec_in = dec_ff + b_ext;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      stop_ff   <= stop_in;
      dec_ff    <= dec_in;
      step_a_ff <= step_a_in;
      step_b_ff <= step_b_in;
      y_down_ff <= y_down_in;
      colour_ff <= colour_in;
   end

endmodule

### rtl/midpoint_line_rasterizer_core.sv
// Channel   Ports                 Moves
// -------   -------------------   ------------------------------------------
// request   req_push / req_full  one command word: start a line or step it
// response  rsp_pop / rsp_empty  one pixel word per step of an active line
//
// One word per clock in both directions when nothing stalls: the front end classifies a
// start combinationally, and the back end makes one pixel per cycle with adds and a sign
// test on the decision term. Two-word queues part front, back and output.
// Synchronous active-high reset empties both queues and idles the walker.
// A full pixel queue stalls the walker; the request side keeps taking words
// until the command queue fills. Starts and idle steps cost no output slot.
// Top level; depends on mlr_pkg, mlr_front, mlr_queue and mlr_back.
module midpoint_line_rasterizer_core
   import mlr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_opcode,
   input  logic signed [IN_W-1:0] req_start_x,
   input  logic signed [IN_W-1:0] req_start_y,
   input  logic signed [IN_W-1:0] req_end_x,
   input  logic signed [IN_W-1:0] req_end_y,
   input  logic [COLOUR_W-1:0]    req_line_colour,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [PIX_W-1:0]       rsp_pixel_col,
   output logic [PIX_W-1:0]       rsp_pixel_row,
   output logic [COLOUR_W-1:0]    rsp_pixel_colour,
   output logic                   rsp_write_enable,
   output logic                   rsp_last_pixel
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int PIX_BITS = $bits(pixel_type);

   cmd_type             front_cmd, back_cmd;
   logic [CMD_W-1:0]    back_cmd_vec;
   logic                cmd_empty, cmd_pop;
   pixel_type           back_pix, out_pix;
   logic [PIX_BITS-1:0] out_pix_vec;
   logic                pix_push, pix_full;

   mlr_front u_front (
      .opcode      (req_opcode),
      .start_x     (req_start_x),
      .start_y     (req_start_y),
      .end_x       (req_end_x),
      .end_y       (req_end_y),
      .line_colour (req_line_colour),
      .cmd         (front_cmd)
   );

   mlr_queue #(.WIDTH(CMD_W)) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  (front_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .data_out (back_cmd_vec),
      .empty    (cmd_empty)
   );

   assign back_cmd = cmd_type'(back_cmd_vec);

   mlr_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .pix       (back_pix),
      .pix_push  (pix_push),
      .pix_full  (pix_full)
   );

   mlr_queue #(.WIDTH(PIX_BITS)) u_pix_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (pix_push),
      .data_in  (back_pix),
      .full     (pix_full),
      .pop      (rsp_pop),
      .data_out (out_pix_vec),
      .empty    (rsp_empty)
   );

   assign out_pix          = pixel_type'(out_pix_vec);
   assign rsp_pixel_col    = out_pix.col;
   assign rsp_pixel_row    = out_pix.row;
   assign rsp_pixel_colour = out_pix.colour;
   assign rsp_write_enable = out_pix.write_enable;
   assign rsp_last_pixel   = out_pix.last;

endmodule

### tb/tb_top.sv
// Self-checking testbench for midpoint_line_rasterizer_core: directed and random line words,
// each step checked against an in-bench line walker. Depends on mlr_pkg and the core RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mlr_pkg::*;

   localparam int SCREEN_W     = DEF_SCREEN_WIDTH;
   localparam int SCREEN_H     = DEF_SCREEN_HEIGHT;
   localparam int RANDOM_WORDS = 1300;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 100;
   localparam int NUM_DIRECTED = 27;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic                   req_opcode;
   logic signed [IN_W-1:0] req_start_x;
   logic signed [IN_W-1:0] req_start_y;
   logic signed [IN_W-1:0] req_end_x;
   logic signed [IN_W-1:0] req_end_y;
   logic [COLOUR_W-1:0]    req_line_colour;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel_col;
   logic [PIX_W-1:0]       rsp_pixel_row;
   logic [COLOUR_W-1:0]    rsp_pixel_colour;
   logic                   rsp_write_enable;
   logic                   rsp_last_pixel;

   midpoint_line_rasterizer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_line_colour  (req_line_colour),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_col    (rsp_pixel_col),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_write_enable (rsp_write_enable),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // walker state, kept at the block's widths
   logic                      ln_active;
   mode_type                  ln_mode;
   logic signed [COORD_W-1:0] ln_x;
   logic signed [COORD_W-1:0] ln_y;
   logic signed [COORD_W-1:0] ln_stop;
   logic signed [DEC_W-1:0]   ln_dec;
   logic signed [STEP_W-1:0]  ln_step_a;
   logic signed [STEP_W-1:0]  ln_step_b;
   logic                      ln_down;
   logic [COLOUR_W-1:0]       ln_colour;

   pixel_type pending_pixels[$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        words_counted = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;

   typedef struct {
      opcode_type op;
      int         sx;
      int         sy;
      int         ex;
      int         ey;
      int         colour;
      bit         typed;
      int         e_col;
      int         e_row;
      int         e_colour;
      bit         e_we;
      bit         e_last;
   } directed_word_type;

   // typed rows: result read straight off the line; the rest go through the walker
   directed_word_type directed_words [NUM_DIRECTED] = '{
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},                       // idle after reset
      '{OP_START, 10, 20, 10, 20, 'hFFFFFF, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 10, 491, 'hFFFFFF, 1, 1},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},                       // line done
      '{OP_START, 0, 0, 511, 511, 0, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFFFF, 1, 0, 511, 0, 1, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_START, -32768, -32768, 32767, 32767, 'hA5A5A5, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 0, 0, 'hA5A5A5, 0, 0},
      '{OP_START, 20, 5, 3, 9, 'h123456, 0, 0, 0, 0, 0, 0},             // abandons, swaps
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 3, 502, 'h123456, 1, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_START, 5, 5, 7, 15, 'h5A5A5A, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_START, 5, 15, 7, 5, 'h0F0F0F, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_START, 511, 0, 512, 0, 'h800001, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 511, 511, 'h800001, 1, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 0, 0, 'h800001, 0, 1},
      '{OP_START, 0, 511, 0, 512, 'h7FFFFE, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 0, 0, 'h7FFFFE, 1, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 0, 0, 'h7FFFFE, 0, 1},
      '{OP_START, -1, -1, -1, -1, 'h000001, 0, 0, 0, 0, 0, 0},
      '{OP_STEP,  0, 0, 0, 0, 0, 1, 0, 0, 'h000001, 0, 1},
      '{OP_START, 32767, -32768, -32768, 32767, 'hC3C3C3, 0, 0, 0, 0, 0, 0}
   };

   task automatic report_error(input string msg);
      if (error_count < MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Advance the line walker by one command word; a step of an active line yields a pixel.
   task automatic raster_step(input opcode_type op,
                              input logic signed [IN_W-1:0] sx, input logic signed [IN_W-1:0] sy,
                              input logic signed [IN_W-1:0] ex, input logic signed [IN_W-1:0] ey,
                              input logic [COLOUR_W-1:0] colour,
                              output bit produced, output pixel_type px);
      int x0, y0, x1, y1, dx, dy, ady, row, tmp;
      bit visible, is_last;
      produced = 1'b0;
      px = '0;
      if (op == OP_START) begin
         x0 = sx;
         y0 = sy;
         x1 = ex;
         y1 = ey;
         if (x1 < x0) begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
         end
         dx = x1 - x0;
         dy = y1 - y0;
         ady = (dy < 0) ? -dy : dy;
         ln_x = COORD_W'(x0);
         ln_y = COORD_W'(y0);
         ln_colour = colour;
         ln_step_a = STEP_W'(2 * ady);
         ln_step_b = STEP_W'(2 * dx);
         ln_down = (dy < 0);
         if (dx >= ady) begin
            ln_mode = MODE_SHALLOW;
            ln_stop = COORD_W'(x1);
            ln_dec = DEC_W'(2 * ady - dx);
         end else if (dy >= 0) begin
            ln_mode = MODE_STEEP_UP;
            ln_stop = COORD_W'(y1);
            ln_dec = DEC_W'(dy - 2 * dx);
         end else begin
            ln_mode = MODE_STEEP_DOWN;
            ln_stop = COORD_W'(y1);
            ln_dec = DEC_W'(2 * dx - ady);
         end
         ln_active = 1'b1;
      end else if (ln_active) begin
         row = SCREEN_H - 1 - int'(ln_y);
         visible = (ln_x >= 0) && (ln_x < SCREEN_W) && (row >= 0) && (row < SCREEN_H);
         px.col = visible ? ln_x[PIX_W-1:0] : '0;
         px.row = visible ? row[PIX_W-1:0] : '0;
         px.colour = ln_colour;
         px.write_enable = visible;
         is_last = (ln_mode == MODE_SHALLOW) ? (ln_x == ln_stop) : (ln_y == ln_stop);
         px.last = is_last;
         produced = 1'b1;
         if (is_last) begin
            ln_active = 1'b0;
         end else begin
            case (ln_mode)
               MODE_SHALLOW: begin
                  if (ln_dec > 0) begin
                     ln_y = ln_down ? ln_y - COORD_W'(1) : ln_y + COORD_W'(1);
                     ln_dec = ln_dec - DEC_W'(ln_step_b);
                  end
                  ln_x = ln_x + COORD_W'(1);
                  ln_dec = ln_dec + DEC_W'(ln_step_a);
               end
               MODE_STEEP_UP: begin
                  if (ln_dec < 0) begin
                     ln_x = ln_x + COORD_W'(1);
                     ln_dec = ln_dec + DEC_W'(ln_step_a);
                  end
                  ln_y = ln_y + COORD_W'(1);
                  ln_dec = ln_dec - DEC_W'(ln_step_b);
               end
               MODE_STEEP_DOWN: begin
                  if (ln_dec > 0) begin
                     ln_x = ln_x + COORD_W'(1);
                     ln_dec = ln_dec - DEC_W'(ln_step_a);
                  end
                  ln_y = ln_y - COORD_W'(1);
                  ln_dec = ln_dec + DEC_W'(ln_step_b);
               end
               default: ;
            endcase
         end
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input opcode_type op, input int sx, input int sy,
                            input int ex, input int ey, input int colour,
                            input bit typed, input pixel_type typed_px);
      bit produced;
      pixel_type px;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_start_x     <= IN_W'(sx);
      req_start_y     <= IN_W'(sy);
      req_end_x       <= IN_W'(ex);
      req_end_y       <= IN_W'(ey);
      req_line_colour <= COLOUR_W'(colour);
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      raster_step(op, IN_W'(sx), IN_W'(sy), IN_W'(ex), IN_W'(ey), COLOUR_W'(colour),
                  produced, px);
      if (produced)
         pending_pixels.push_back(typed ? typed_px : px);
      if (op == OP_START || produced)
         words_counted++;
      @(negedge clock);
   endtask

   task automatic send_line();
      int kind, x0, y0, x1, y1, len, nsteps, r, adx, ady;
      pixel_type none;
      none = '0;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // noise: any opcode, any fields
         send_word(opcode_type'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                   $urandom, 1'b0, none);
         return;
      end
      if (kind < 22) begin
         // full coordinate range; long, so cut short by the next start
         x0 = $urandom; y0 = $urandom; x1 = $urandom; y1 = $urandom;
         nsteps = $urandom_range(12, 1);
      end else begin
         x0 = int'($urandom_range(551)) - 20;
         y0 = int'($urandom_range(551)) - 20;
         x1 = x0 + int'($urandom_range(80)) - 40;
         y1 = y0 + int'($urandom_range(80)) - 40;
         r = $urandom_range(9);
         if (r == 0)
            y1 = y0;
         else if (r == 1)
            x1 = x0;
         adx = (x1 > x0) ? x1 - x0 : x0 - x1;
         ady = (y1 > y0) ? y1 - y0 : y0 - y1;
         len = ((adx > ady) ? adx : ady) + 1;
         r = $urandom_range(9);
         if (r < 7)
            nsteps = len;
         else if (r < 9)
            nsteps = len + $urandom_range(2, 1);
         else
            nsteps = $urandom_range(len - 1);
      end
      send_word(OP_START, x0, y0, x1, y1, $urandom, 1'b0, none);
      repeat (nsteps)
         send_word(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
   endtask

   always @(negedge clock)
      rsp_pop <= !reset && ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_pixel_col, rsp_pixel_row, rsp_pixel_colour, rsp_write_enable,
                rsp_last_pixel};
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("unexpected pixel word col %0d row %0d", got.col, got.row));
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_col", got.col, want.col);
            check_field("pixel_row", got.row, want.row);
            check_field("pixel_colour", got.colour, want.colour);
            check_field("write_enable", got.write_enable, want.write_enable);
            check_field("last_pixel", got.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      directed_word_type d;
      int phase;
      int start_count;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_opcode      = OP_START;
      req_start_x     = '0;
      req_start_y     = '0;
      req_end_x       = '0;
      req_end_y       = '0;
      req_line_colour = '0;
      ln_active = 1'b0;
      ln_mode   = MODE_SHALLOW;
      ln_x      = '0;
      ln_y      = '0;
      ln_stop   = '0;
      ln_dec    = '0;
      ln_step_a = '0;
      ln_step_b = '0;
      ln_down   = 1'b0;
      ln_colour = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) begin
         d = directed_words[i];
         send_word(d.op, d.sx, d.sy, d.ex, d.ey, d.colour, d.typed,
                   {PIX_W'(d.e_col), PIX_W'(d.e_row), COLOUR_W'(d.e_colour), d.e_we, d.e_last});
      end

      // no idling, sender idle, receiver stalling, then both
      start_count = words_counted;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 18 : 0;
         recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 18 : 0;
         while (words_counted - start_count < (phase + 1) * RANDOM_WORDS / 4)
            send_line();
      end
      req_push <= 1'b0;

      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
